@@ src/leader_clustering_running_mean_unit_assert.svh @@
// assertion macros for the leader clustering running mean unit
// no dependencies; included by the modules that carry assertions
`ifndef LEADER_CLUSTERING_RUNNING_MEAN_UNIT_ASSERT_SVH
`define LEADER_CLUSTERING_RUNNING_MEAN_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define LCRM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define LCRM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define LCRM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)

`define LCRM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ src/lcrm_pkg.sv @@
// shared constants, types and controller encoding of the leader clustering unit
// no dependencies
package lcrm_pkg;

   localparam int MAX_CLUSTERS  = 64;
   localparam int FRACTION_BITS = 16;
   localparam int COUNT_BITS    = 16;

   localparam int IDX_W   = $clog2(MAX_CLUSTERS);
   localparam int TOTAL_W = $clog2(MAX_CLUSTERS + 1);
   localparam int FRAC_W  = FRACTION_BITS;
   localparam int COUNT_W = COUNT_BITS;
   localparam int SUM_W   = FRACTION_BITS + COUNT_BITS;
   localparam int THR_W   = 16;
   localparam int STEP_W  = $clog2(FRACTION_BITS);

   localparam logic [THR_W-1:0]   THRESH_RESET = THR_W'(3277);
   localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX    = TOTAL_W'(MAX_CLUSTERS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_LOAD,
      S_DIV,
      S_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan_issue;
      logic read_best;
      logic do_clear;
      logic do_open;
      logic do_full;
      logic sat_result;
      logic div_start;
      logic write_join;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic table_empty;
      logic table_full;
      logic last_issue;
      logic join_ok;
      logic count_sat;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

@@ src/lcrm_if.sv @@
// valid/ready channel interfaces for request and response transactions
// depends on lcrm_pkg
interface lcrm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [lcrm_pkg::FRAC_W-1:0] frequency;

   modport source (output valid, kind, frequency, input ready);
   modport sink (input valid, kind, frequency, output ready);
endinterface

interface lcrm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lcrm_pkg::IDX_W-1:0]   cluster_index;
   logic                         opened_new;
   logic [lcrm_pkg::FRAC_W-1:0]  centroid;
   logic [lcrm_pkg::TOTAL_W-1:0] cluster_total;
   logic                         table_full;

   modport source (output valid, cluster_index, opened_new, centroid, cluster_total,
                   table_full, input ready);
   modport sink (input valid, cluster_index, opened_new, centroid, cluster_total,
                 table_full, output ready);
endinterface

@@ src/lcrm_div.sv @@
// restoring divider for the running mean, one quotient bit per cycle
// depends on lcrm_pkg and the assertion header
`include "leader_clustering_running_mean_unit_assert.svh"

module lcrm_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lcrm_pkg::SUM_W-1:0]   dividend,
   input  logic [lcrm_pkg::COUNT_W-1:0] divisor,
   output logic                         done,
   output logic [lcrm_pkg::FRAC_W-1:0]  quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [lcrm_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [lcrm_pkg::COUNT_W-1:0]  rem_ff, rem_in;
   logic [lcrm_pkg::FRAC_W-1:0]   quo_ff, quo_in;
   logic [lcrm_pkg::COUNT_W-1:0]  dvs_ff, dvs_in;
   logic [lcrm_pkg::COUNT_W:0]    trial;
   logic [lcrm_pkg::COUNT_W:0]    diff;
   logic                          ge;
   logic                          last_step;

   assign trial     = {rem_ff, quo_ff[lcrm_pkg::FRAC_W-1]};
   assign diff      = trial - {1'b0, dvs_ff};
   assign ge        = (trial >= {1'b0, dvs_ff});
   assign last_step = (step_ff == lcrm_pkg::STEP_W'(lcrm_pkg::FRAC_W - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = dividend[lcrm_pkg::SUM_W-1:lcrm_pkg::FRAC_W];
         quo_in  = dividend[lcrm_pkg::FRAC_W-1:0];
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[lcrm_pkg::COUNT_W-1:0] : trial[lcrm_pkg::COUNT_W-1:0];
         quo_in  = {quo_ff[lcrm_pkg::FRAC_W-2:0], ge};
         step_in = step_ff + lcrm_pkg::STEP_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // the mean never exceeds the largest frequency, so the quotient fits
   `LCRM_ASSERT_SAME(a_div_fits, clock, reset, start,
      dividend[lcrm_pkg::SUM_W-1:lcrm_pkg::FRAC_W] < divisor, "mean quotient overflow")

endmodule

@@ src/lcrm_ctrl.sv @@
// controller state machine: sequences accept, scan, decision, division and response
// depends on lcrm_pkg and the assertion header
`include "leader_clustering_running_mean_unit_assert.svh"

module lcrm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lcrm_pkg::dp_status_type status,
   output lcrm_pkg::dp_cmd_type    cmd
);

   lcrm_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcrm_pkg::S_IDLE: begin
            if (req_valid) state_in = lcrm_pkg::S_START;
         end
         lcrm_pkg::S_START: begin
            if (status.is_clear || status.table_empty) begin
               state_in = lcrm_pkg::S_RESP;
            end else if (status.last_issue) begin
               state_in = lcrm_pkg::S_DRAIN;
            end else begin
               state_in = lcrm_pkg::S_SCAN;
            end
         end
         lcrm_pkg::S_SCAN: begin
            if (status.last_issue) state_in = lcrm_pkg::S_DRAIN;
         end
         lcrm_pkg::S_DRAIN: begin
            state_in = lcrm_pkg::S_DECIDE;
         end
         lcrm_pkg::S_DECIDE: begin
            state_in = status.join_ok ? lcrm_pkg::S_LOAD : lcrm_pkg::S_RESP;
         end
         lcrm_pkg::S_LOAD: begin
            state_in = status.count_sat ? lcrm_pkg::S_RESP : lcrm_pkg::S_DIV;
         end
         lcrm_pkg::S_DIV: begin
            if (status.div_done) state_in = lcrm_pkg::S_RESP;
         end
         lcrm_pkg::S_RESP: begin
            if (status.out_free) state_in = lcrm_pkg::S_IDLE;
         end
         default: begin
            state_in = lcrm_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         lcrm_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         lcrm_pkg::S_START: begin
            if (status.is_clear) begin
               cmd.do_clear = 1'b1;
            end else if (status.table_empty) begin
               cmd.do_open = 1'b1;
            end else begin
               cmd.scan_issue = 1'b1;
            end
         end
         lcrm_pkg::S_SCAN: begin
            cmd.scan_issue = 1'b1;
         end
         lcrm_pkg::S_DRAIN: begin
         end
         lcrm_pkg::S_DECIDE: begin
            if (status.join_ok) begin
               cmd.read_best = 1'b1;
            end else if (status.table_full) begin
               cmd.do_full = 1'b1;
            end else begin
               cmd.do_open = 1'b1;
            end
         end
         lcrm_pkg::S_LOAD: begin
            if (status.count_sat) begin
               cmd.sat_result = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
            end
         end
         lcrm_pkg::S_DIV: begin
            cmd.write_join = status.div_done;
         end
         lcrm_pkg::S_RESP: begin
            cmd.load_out = status.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcrm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // the divider reports completion only while the controller waits for it
   `LCRM_ASSERT_SAME(a_div_done_in_div, clock, reset, status.div_done,
      state_ff == lcrm_pkg::S_DIV, "divider done outside of division wait")

endmodule

@@ src/lcrm_dp.sv @@
// datapath: cluster stores, nearest-centroid scan, running sums and result registers
// depends on lcrm_pkg, lcrm_div and the assertion header
`include "leader_clustering_running_mean_unit_assert.svh"

module lcrm_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  lcrm_pkg::dp_cmd_type          cmd,
   output lcrm_pkg::dp_status_type       status,
   input  logic                          req_kind,
   input  logic [lcrm_pkg::FRAC_W-1:0]   req_frequency,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [lcrm_pkg::IDX_W-1:0]    rsp_cluster_index,
   output logic                          rsp_opened_new,
   output logic [lcrm_pkg::FRAC_W-1:0]   rsp_centroid,
   output logic [lcrm_pkg::TOTAL_W-1:0]  rsp_cluster_total,
   output logic                          rsp_table_full,
   input  logic                          csr_wr_en,
   input  logic [lcrm_pkg::THR_W-1:0]    csr_wr_data
);

   // cluster stores
   logic [lcrm_pkg::FRAC_W-1:0]  cen_mem [lcrm_pkg::MAX_CLUSTERS];
   logic [lcrm_pkg::SUM_W-1:0]   sum_mem [lcrm_pkg::MAX_CLUSTERS];
   logic [lcrm_pkg::COUNT_W-1:0] cnt_mem [lcrm_pkg::MAX_CLUSTERS];

   logic [lcrm_pkg::THR_W-1:0]   thresh_ff;
   logic                         kind_ff;
   logic [lcrm_pkg::FRAC_W-1:0]  freq_ff;
   logic [lcrm_pkg::TOTAL_W-1:0] clusters_ff;
   logic [lcrm_pkg::IDX_W-1:0]   scan_addr_ff;
   logic                         cmp_vld_ff;
   logic [lcrm_pkg::IDX_W-1:0]   cmp_idx_ff;
   logic [lcrm_pkg::FRAC_W-1:0]  cen_rd_ff;
   logic [lcrm_pkg::FRAC_W-1:0]  best_diff_ff;
   logic [lcrm_pkg::IDX_W-1:0]   best_idx_ff;
   logic [lcrm_pkg::FRAC_W-1:0]  best_cen_ff;
   logic [lcrm_pkg::SUM_W-1:0]   sum_rd_ff;
   logic [lcrm_pkg::COUNT_W-1:0] cnt_rd_ff;
   logic [lcrm_pkg::SUM_W-1:0]   sum_new_ff;
   logic [lcrm_pkg::COUNT_W-1:0] cnt_new_ff;

   logic [lcrm_pkg::IDX_W-1:0]   res_idx_ff;
   logic                         res_open_ff;
   logic [lcrm_pkg::FRAC_W-1:0]  res_cen_ff;
   logic [lcrm_pkg::TOTAL_W-1:0] res_total_ff;
   logic                         res_full_ff;

   logic                         rsp_valid_ff;
   logic [lcrm_pkg::IDX_W-1:0]   rsp_idx_ff;
   logic                         rsp_open_ff;
   logic [lcrm_pkg::FRAC_W-1:0]  rsp_cen_ff;
   logic [lcrm_pkg::TOTAL_W-1:0] rsp_total_ff;
   logic                         rsp_full_ff;

   logic [lcrm_pkg::FRAC_W-1:0]  diff;
   logic                         better;
   logic [lcrm_pkg::SUM_W-1:0]   sum_new;
   logic [lcrm_pkg::COUNT_W-1:0] cnt_new;
   logic                         mem_we;
   logic [lcrm_pkg::IDX_W-1:0]   mem_addr;
   logic [lcrm_pkg::FRAC_W-1:0]  cen_wdata;
   logic [lcrm_pkg::SUM_W-1:0]   sum_wdata;
   logic [lcrm_pkg::COUNT_W-1:0] cnt_wdata;
   logic                         div_done;
   logic [lcrm_pkg::FRAC_W-1:0]  quotient;
   logic                         out_free;

   assign diff    = (cen_rd_ff >= freq_ff) ? (cen_rd_ff - freq_ff) : (freq_ff - cen_rd_ff);
   assign better  = (cmp_idx_ff == '0) || (diff < best_diff_ff);
   assign sum_new = sum_rd_ff + lcrm_pkg::SUM_W'(freq_ff);
   assign cnt_new = cnt_rd_ff + lcrm_pkg::COUNT_W'(1);

   assign mem_we    = cmd.do_open || cmd.write_join;
   assign mem_addr  = cmd.do_open ? clusters_ff[lcrm_pkg::IDX_W-1:0] : best_idx_ff;
   assign cen_wdata = cmd.do_open ? freq_ff : quotient;
   assign sum_wdata = cmd.do_open ? lcrm_pkg::SUM_W'(freq_ff) : sum_new_ff;
   assign cnt_wdata = cmd.do_open ? lcrm_pkg::COUNT_W'(1) : cnt_new_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      status.is_clear    = kind_ff;
      status.table_empty = (clusters_ff == '0);
      status.table_full  = (clusters_ff == lcrm_pkg::TOTAL_MAX);
      status.last_issue  = ((lcrm_pkg::TOTAL_W'(scan_addr_ff) + lcrm_pkg::TOTAL_W'(1))
                            == clusters_ff);
      status.join_ok     = (lcrm_pkg::THR_W'(best_diff_ff) <= thresh_ff);
      status.count_sat   = (cnt_rd_ff == lcrm_pkg::COUNT_MAX);
      status.div_done    = div_done;
      status.out_free    = out_free;
   end

   lcrm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_new),
      .divisor  (cnt_new),
      .done     (div_done),
      .quotient (quotient)
   );

   // memories
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cen_mem[mem_addr] <= cen_wdata;
         sum_mem[mem_addr] <= sum_wdata;
         cnt_mem[mem_addr] <= cnt_wdata;
      end
   end

   always_ff @(posedge clock) begin
      cen_rd_ff <= cen_mem[scan_addr_ff];
      if (cmd.read_best) begin
         sum_rd_ff <= sum_mem[best_idx_ff];
         cnt_rd_ff <= cnt_mem[best_idx_ff];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= lcrm_pkg::THRESH_RESET;
         clusters_ff  <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) thresh_ff <= csr_wr_data;
         if (cmd.do_clear) begin
            clusters_ff <= '0;
         end else if (cmd.do_open) begin
            clusters_ff <= clusters_ff + lcrm_pkg::TOTAL_W'(1);
         end
         cmp_vld_ff <= cmd.scan_issue;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff      <= req_kind;
         freq_ff      <= req_frequency;
         scan_addr_ff <= '0;
      end else if (cmd.scan_issue) begin
         scan_addr_ff <= scan_addr_ff + lcrm_pkg::IDX_W'(1);
      end
      cmp_idx_ff <= scan_addr_ff;
      if (cmp_vld_ff && better) begin
         best_diff_ff <= diff;
         best_idx_ff  <= cmp_idx_ff;
         best_cen_ff  <= cen_rd_ff;
      end
      if (cmd.div_start) begin
         sum_new_ff <= sum_new;
         cnt_new_ff <= cnt_new;
      end
      if (cmd.do_clear) begin
         res_idx_ff   <= '0;
         res_open_ff  <= 1'b0;
         res_cen_ff   <= '0;
         res_total_ff <= '0;
         res_full_ff  <= 1'b0;
      end else if (cmd.do_full) begin
         res_idx_ff   <= '0;
         res_open_ff  <= 1'b0;
         res_cen_ff   <= '0;
         res_total_ff <= lcrm_pkg::TOTAL_MAX;
         res_full_ff  <= 1'b1;
      end else if (cmd.do_open) begin
         res_idx_ff   <= clusters_ff[lcrm_pkg::IDX_W-1:0];
         res_open_ff  <= 1'b1;
         res_cen_ff   <= freq_ff;
         res_total_ff <= clusters_ff + lcrm_pkg::TOTAL_W'(1);
         res_full_ff  <= 1'b0;
      end else if (cmd.sat_result || cmd.write_join) begin
         res_idx_ff   <= best_idx_ff;
         res_open_ff  <= 1'b0;
         res_cen_ff   <= cmd.write_join ? quotient : best_cen_ff;
         res_total_ff <= clusters_ff;
         res_full_ff  <= 1'b0;
      end
      if (cmd.load_out) begin
         rsp_idx_ff   <= res_idx_ff;
         rsp_open_ff  <= res_open_ff;
         rsp_cen_ff   <= res_cen_ff;
         rsp_total_ff <= res_total_ff;
         rsp_full_ff  <= res_full_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cluster_index = rsp_idx_ff;
   assign rsp_opened_new    = rsp_open_ff;
   assign rsp_centroid      = rsp_cen_ff;
   assign rsp_cluster_total = rsp_total_ff;
   assign rsp_table_full    = rsp_full_ff;

   `LCRM_ASSERT_SAME(a_total_in_range, clock, reset, 1'b1,
      clusters_ff <= lcrm_pkg::TOTAL_MAX, "cluster total beyond table size")
   `LCRM_ASSERT_SAME(a_open_has_room, clock, reset, cmd.do_open,
      clusters_ff < lcrm_pkg::TOTAL_MAX, "cluster opened in a full table")
   `LCRM_ASSERT_NEXT(a_open_counts, clock, reset, cmd.do_open && !cmd.do_clear,
      clusters_ff == $past(clusters_ff) + lcrm_pkg::TOTAL_W'(1), "open did not count up")

endmodule

@@ src/leader_clustering_running_mean_unit.sv @@
// Online 1-D leader clustering of event frequencies (unsigned Q0.16) with running-mean
// centroids in a 64-entry table. One transaction at a time: a clear or an event into an
// empty table goes from the start state straight to the response state; any other event
// runs a scan that reads one centroid per cycle from the centroid memory over the n
// clusters in use, then a drain, a decision and a response step. Joining a saturated
// cluster adds a load step, and joining an unsaturated cluster adds a load step and the
// 16-step mean divider. The input is ready again the cycle after the response is loaded.
// The response sits in an output register, so a new transaction is taken while a
// response still waits. Stores need no clearing pass after reset.
// Depends on lcrm_pkg, lcrm_if, lcrm_ctrl and lcrm_dp.
module leader_clustering_running_mean_unit (
   input  logic                        clock,
   input  logic                        reset,
   lcrm_req_if.sink                    req_chan,
   lcrm_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [lcrm_pkg::THR_W-1:0]  csr_wr_data
);

   lcrm_pkg::dp_cmd_type    cmd;
   lcrm_pkg::dp_status_type status;

   lcrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lcrm_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_chan.kind),
      .req_frequency     (req_chan.frequency),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_cluster_index (rsp_chan.cluster_index),
      .rsp_opened_new    (rsp_chan.opened_new),
      .rsp_centroid      (rsp_chan.centroid),
      .rsp_cluster_total (rsp_chan.cluster_total),
      .rsp_table_full    (rsp_chan.table_full),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

endmodule

@@ tb/sv/lcrm_cluster_check_pkg.sv @@
`timescale 1ns / 100ps
// scoreboard for the leader clustering running mean unit: predicts the response of each
// accepted request transaction and checks responses in order; depends on lcrm_pkg
package lcrm_cluster_check_pkg;
   import lcrm_pkg::*;

   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   typedef struct packed {
      logic [IDX_W-1:0]   cluster_index;
      logic               opened_new;
      logic [FRAC_W-1:0]  centroid;
      logic [TOTAL_W-1:0] cluster_total;
      logic               table_full;
   } assignment_type;

   class cluster_scoreboard;
      logic [FRAC_W-1:0]  centroids [MAX_CLUSTERS];
      logic [SUM_W-1:0]   sums      [MAX_CLUSTERS];
      logic [COUNT_W-1:0] counts    [MAX_CLUSTERS];
      logic [TOTAL_W-1:0] in_use;
      logic [THR_W-1:0]   join_limit;
      assignment_type     awaited_assignments [$];
      int                 errors;

      function new();
         in_use     = '0;
         join_limit = THRESH_RESET;
         errors     = 0;
      endfunction

      function void set_threshold(logic [THR_W-1:0] value);
         join_limit = value;
      endfunction

      function int outstanding();
         return awaited_assignments.size();
      endfunction

      function assignment_type assign_cluster(logic kind, logic [FRAC_W-1:0] freq);
         assignment_type    result;
         logic [FRAC_W-1:0] gap;
         logic [FRAC_W-1:0] best_gap;
         int                best;
         int                n;
         result   = '0;
         best     = 0;
         best_gap = '0;
         if (kind == KIND_CLEAR) begin
            in_use = '0;
            return result;
         end
         n = int'(in_use);
         for (int i = 0; i < n; i++) begin
            gap = (centroids[i] >= freq) ? centroids[i] - freq : freq - centroids[i];
            if (i == 0 || gap < best_gap) begin
               best_gap = gap;
               best     = i;
            end
         end
         if (n > 0 && best_gap <= join_limit) begin
            // saturated count keeps count, sum and centroid as they are
            if (counts[best] != COUNT_MAX) begin
               counts[best]    = counts[best] + 1'b1;
               sums[best]      = sums[best] + SUM_W'(freq);
               centroids[best] = FRAC_W'(sums[best] / SUM_W'(counts[best]));
            end
            result.cluster_index = IDX_W'(best);
            result.centroid      = centroids[best];
            result.cluster_total = in_use;
         end else if (n >= MAX_CLUSTERS) begin
            result.cluster_total = TOTAL_MAX;
            result.table_full    = 1'b1;
         end else begin
            centroids[n] = freq;
            sums[n]      = SUM_W'(freq);
            counts[n]    = COUNT_W'(1);
            in_use       = in_use + 1'b1;
            result.cluster_index = IDX_W'(n);
            result.opened_new    = 1'b1;
            result.centroid      = freq;
            result.cluster_total = in_use;
         end
         return result;
      endfunction

      function void note_request(logic kind, logic [FRAC_W-1:0] freq);
         awaited_assignments.insert(awaited_assignments.size(), assign_cluster(kind, freq));
      endfunction

      function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
         if (exp_val != act_val) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_response(assignment_type got);
         assignment_type want;
         if (awaited_assignments.size() == 0) begin
            $display("%0t response with no transaction pending: expected none actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = awaited_assignments.pop_front();
         compare_field("cluster_index", want.cluster_index, got.cluster_index);
         compare_field("opened_new", want.opened_new, got.opened_new);
         compare_field("centroid", want.centroid, got.centroid);
         compare_field("cluster_total", want.cluster_total, got.cluster_total);
         compare_field("table_full", want.table_full, got.table_full);
      endfunction
   endclass

endpackage

@@ tb/sv/tb_leader_clustering_running_mean_unit.sv @@
`timescale 1ns / 100ps
// top testbench of the leader clustering running mean unit: directed and random request
// transactions under several idle patterns and thresholds, checked by the scoreboard
// depends on lcrm_pkg, lcrm_if, lcrm_cluster_check_pkg and the unit itself
module tb_leader_clustering_running_mean_unit;
   import lcrm_pkg::*;
   import lcrm_cluster_check_pkg::*;

   localparam int     CLOCK_HALF    = 4;
   localparam int     RESET_CYCLES  = 12;
   localparam int     PHASE_COUNT   = 12;
   localparam int     PHASE_ITEMS   = 120;
   localparam int     SETTLE_CYCLES = 200;
   localparam longint CYCLE_LIMIT   = 10_000_000;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [THR_W-1:0] csr_wr_data;

   lcrm_req_if req_bus ();
   lcrm_rsp_if rsp_bus ();

   leader_clustering_running_mean_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   cluster_scoreboard board;
   int                sender_idle_pct    = 0;
   int                receiver_stall_pct = 0;
   longint            cycle_count        = 0;
   int                phase;
   int                item;
   int                roll;
   int                span;
   int                freq_val;
   logic [THR_W-1:0]  join_limit;
   logic [FRAC_W-1:0] anchors [8];

   always #CLOCK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL leader_clustering_running_mean_unit");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         board.check_response({rsp_bus.cluster_index, rsp_bus.opened_new, rsp_bus.centroid,
                               rsp_bus.cluster_total, rsp_bus.table_full});
      end
   end

   task automatic send_item(input logic kind, input logic [FRAC_W-1:0] freq);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= kind;
      req_bus.frequency <= freq;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      board.note_request(kind, freq);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_threshold(value);
   endtask

   initial begin
      board = new();
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.kind      <= KIND_EVENT;
      req_bus.frequency <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset threshold: empty table, boundary join, ties toward the lower index
      send_item(KIND_CLEAR, 16'hFFFF);
      send_item(KIND_EVENT, 16'h0000);
      send_item(KIND_EVENT, 16'hFFFF);
      send_item(KIND_EVENT, 16'd3277);
      send_item(KIND_EVENT, 16'd3277);
      send_item(KIND_EVENT, 16'hFFFF - 16'd3278);
      send_item(KIND_CLEAR, 16'h1234);
      send_item(KIND_EVENT, 16'd10000);
      send_item(KIND_EVENT, 16'd14000);
      send_item(KIND_EVENT, 16'd12000);
      send_item(KIND_EVENT, 16'd12500);
      drain_results();
      write_threshold(16'hFFFF);
      send_item(KIND_EVENT, 16'h0001);
      send_item(KIND_EVENT, 16'hFFFE);
      drain_results();
      write_threshold(16'h0000);
      send_item(KIND_EVENT, 16'h0001);
      send_item(KIND_EVENT, 16'h0001);
      send_item(KIND_EVENT, 16'h0002);
      drain_results();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 49;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 49;
            end
            default: begin
               sender_idle_pct    = 11;
               receiver_stall_pct = 11;
            end
         endcase
         case (phase % 6)
            0: join_limit = 16'h0000;
            1: join_limit = 16'hFFFF;
            2: join_limit = THRESH_RESET;
            3: join_limit = 16'($urandom_range(65535));
            4: join_limit = 16'h0001;
            default: join_limit = 16'($urandom_range(2000));
         endcase
         write_threshold(join_limit);
         foreach (anchors[a]) anchors[a] = 16'($urandom_range(65535));
         span = int'(join_limit) * 3 + 16;
         if (span > 65535) span = 65535;
         for (item = 0; item < PHASE_ITEMS; item++) begin
            roll = $urandom_range(99);
            if (roll < 3) begin
               send_item(KIND_CLEAR, 16'($urandom_range(65535)));
            end else begin
               if (roll < 33) begin
                  freq_val = $urandom_range(65535);
               end else if (roll < 41) begin
                  freq_val = (roll % 2 != 0) ? 65535 : 0;
               end else begin
                  // near a centroid: joins, near misses and ties
                  freq_val = int'(anchors[$urandom_range(7)]) + int'($urandom_range(span))
                             - span / 2;
                  if (freq_val < 0) freq_val = 0;
                  else if (freq_val > 65535) freq_val = 65535;
               end
               send_item(KIND_EVENT, 16'(freq_val));
            end
            if (item % 40 == 39 && item != PHASE_ITEMS - 1) drain_results();
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("PASS leader_clustering_running_mean_unit");
      end else begin
         $display("FAIL leader_clustering_running_mean_unit");
      end
      $finish;
   end

endmodule
